// ===== src/atbc_pkg.sv =====
`default_nettype none
package atbc_pkg;

   localparam int MAX_TEXT_CHARS_DEF = 32;
   localparam int DIV_W = 16;
   localparam int LANES = 8;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_COMPOSITE = 1'b1;

   localparam logic FMT_1BPP = 1'b0;
   localparam logic FMT_2BPP = 1'b1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ARG = 2'd1;
   localparam logic [1:0] ST_FIT = 2'd2;

   localparam logic [2:0] REG_FRAME_WIDTH = 3'd0;
   localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
   localparam logic [2:0] REG_PIXEL_FORMAT = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X = 3'd3;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd4;
   localparam logic [2:0] REG_GLYPH_SCALE = 3'd5;
   localparam logic [2:0] REG_TEXT_LENGTH = 3'd6;

   // reciprocal of 6 scaled by 1024
   localparam int RECIP6 = 171;
   localparam int RECIP6_SHIFT = 10;

   typedef struct packed {
      logic vld;
      logic cmd;
      logic [4:0] slot;
      logic [7:0] code;
      logic [7:0] byte_in;
      logic yin;
   } meta_type;

   function automatic logic glyph_ok(input logic [7:0] code);
      logic ok;
      ok = 1'b0;
      case (code) inside
         [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]: ok = 1'b1;
         8'h20, 8'h21, 8'h2D, 8'h2E, 8'h3A, 8'h3F, 8'h5F: ok = 1'b1;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   // seven 5-bit rows, top row in the high bits
   function automatic logic [34:0] glyph_rows(input logic [7:0] code);
      logic [34:0] r;
      r = '0;
      case (code)
         8'h41: r = {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
         8'h42: r = {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E};
         8'h43: r = {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E};
         8'h44: r = {5'h1E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h1E};
         8'h45: r = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F};
         8'h46: r = {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10};
         8'h47: r = {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F};
         8'h48: r = {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11};
         8'h49: r = {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h4A: r = {5'h07,5'h02,5'h02,5'h02,5'h12,5'h12,5'h0C};
         8'h4B: r = {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11};
         8'h4C: r = {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F};
         8'h4D: r = {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11};
         8'h4E: r = {5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11};
         8'h4F: r = {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         8'h50: r = {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10};
         8'h51: r = {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D};
         8'h52: r = {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11};
         8'h53: r = {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E};
         8'h54: r = {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04};
         8'h55: r = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E};
         8'h56: r = {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04};
         8'h57: r = {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A};
         8'h58: r = {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11};
         8'h59: r = {5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04};
         8'h5A: r = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F};
         8'h61: r = {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F};
         8'h62: r = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E};
         8'h63: r = {5'h00,5'h00,5'h0F,5'h10,5'h10,5'h10,5'h0F};
         8'h64: r = {5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F};
         8'h65: r = {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E};
         8'h66: r = {5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08};
         8'h67: r = {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h0E};
         8'h68: r = {5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h11};
         8'h69: r = {5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E};
         8'h6A: r = {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C};
         8'h6B: r = {5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12};
         8'h6C: r = {5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h6D: r = {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15};
         8'h6E: r = {5'h00,5'h00,5'h1E,5'h11,5'h11,5'h11,5'h11};
         8'h6F: r = {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E};
         8'h70: r = {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10};
         8'h71: r = {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h01};
         8'h72: r = {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10};
         8'h73: r = {5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E};
         8'h74: r = {5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06};
         8'h75: r = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D};
         8'h76: r = {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04};
         8'h77: r = {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A};
         8'h78: r = {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11};
         8'h79: r = {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h0E};
         8'h7A: r = {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F};
         8'h30: r = {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E};
         8'h31: r = {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E};
         8'h32: r = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F};
         8'h33: r = {5'h1E,5'h01,5'h01,5'h0E,5'h01,5'h01,5'h1E};
         8'h34: r = {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02};
         8'h35: r = {5'h1F,5'h10,5'h10,5'h1E,5'h01,5'h01,5'h1E};
         8'h36: r = {5'h0E,5'h10,5'h10,5'h1E,5'h11,5'h11,5'h0E};
         8'h37: r = {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08};
         8'h38: r = {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E};
         8'h39: r = {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h01,5'h0E};
         8'h21: r = {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04};
         8'h2D: r = {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00};
         8'h2E: r = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h04};
         8'h3A: r = {5'h00,5'h04,5'h00,5'h00,5'h04,5'h00,5'h00};
         8'h3F: r = {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04};
         8'h5F: r = {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F};
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] glyph_row(input logic [7:0] code, input logic [2:0] gy);
      logic [34:0] r;
      logic [4:0] row;
      r = glyph_rows(code);
      case (gy)
         3'd0: row = r[34:30];
         3'd1: row = r[29:25];
         3'd2: row = r[24:20];
         3'd3: row = r[19:15];
         3'd4: row = r[14:10];
         3'd5: row = r[9:5];
         3'd6: row = r[4:0];
         default: row = 5'd0;
      endcase
      return row;
   endfunction

endpackage
`default_nettype wire

// ===== src/atbc_div.sv =====
`default_nettype none
module atbc_div
   import atbc_pkg::*;
(
   input wire logic clock,
   input wire logic enable,
   input wire logic [7:0] divisor,
   input wire logic [DIV_W-1:0] dividend,
   output logic [DIV_W-1:0] quotient
);

   // one quotient bit per stage, restoring
   logic [7:0] rem_ff [0:DIV_W-1];
   logic [DIV_W-1:0] num_ff [0:DIV_W-1];
   logic [7:0] rem_in [0:DIV_W-1];
   logic [DIV_W-1:0] num_in [0:DIV_W-1];

   always_comb begin
      for (int j = 0; j < DIV_W; j++) begin
         logic [7:0] rp;
         logic [DIV_W-1:0] np;
         logic [8:0] trial;
         logic ge;
         rp = (j == 0) ? 8'd0 : rem_ff[(j == 0) ? 0 : j-1];
         np = (j == 0) ? dividend : num_ff[(j == 0) ? 0 : j-1];
         trial = {rp, np[DIV_W-1]};
         ge = (trial >= {1'b0, divisor});
         rem_in[j] = ge ? 8'(trial - {1'b0, divisor}) : trial[7:0];
         num_in[j] = {np[DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int j = 0; j < DIV_W; j++) begin
            rem_ff[j] <= rem_in[j];
            num_ff[j] <= num_in[j];
         end
      end
   end

   assign quotient = num_ff[DIV_W-1];

endmodule
`default_nettype wire

// ===== src/atbc_lane.sv =====
`default_nettype none
module atbc_lane
   import atbc_pkg::*;
#(
   parameter int MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
   input wire logic clock,
   input wire logic enable,
   input wire logic lane_en,
   input wire logic [16:0] px,
   input wire logic [15:0] origin_x,
   input wire logic [15:0] text_w,
   input wire logic [7:0] scale,
   output logic xin,
   output logic [((MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1)-1:0] char_idx,
   output logic [2:0] gx
);

   localparam int IW = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;
   localparam int CW = $clog2(6 * MAX_TEXT_CHARS);
   localparam int PW = CW + 8;

   logic [16:0] dx;
   logic in_x;
   logic in_pipe_ff [0:DIV_W-1];
   logic [DIV_W-1:0] quo;
   logic [CW-1:0] col;
   logic [PW-1:0] prod;
   logic [IW-1:0] cell_in;
   logic [CW-1:0] gx_full;
   logic xin_ff;
   logic [IW-1:0] cell_ff;
   logic [2:0] gx_ff;

   assign dx = px - {1'b0, origin_x};
   assign in_x = lane_en && (px >= {1'b0, origin_x}) && (dx < {1'b0, text_w});

   atbc_div u_div (
      .clock(clock),
      .enable(enable),
      .divisor(scale),
      .dividend(dx[15:0]),
      .quotient(quo)
   );

   always_ff @(posedge clock) begin
      if (enable) begin
         in_pipe_ff[0] <= in_x;
         for (int j = 1; j < DIV_W; j++) begin
            in_pipe_ff[j] <= in_pipe_ff[j-1];
         end
      end
   end

   // cell = col / 6 by reciprocal, exact over the text box
   assign col = CW'(quo);
   assign prod = PW'(col) * PW'(RECIP6);
   assign cell_in = IW'(prod >> RECIP6_SHIFT);
   assign gx_full = col - CW'(CW'(cell_in) * CW'(6));

   always_ff @(posedge clock) begin
      if (enable) begin
         xin_ff <= in_pipe_ff[DIV_W-1];
         cell_ff <= cell_in;
         gx_ff <= gx_full[2:0];
      end
   end

   assign xin = xin_ff;
   assign char_idx = cell_ff;
   assign gx = gx_ff;

endmodule
`default_nettype wire

// ===== src/ascii_text_byte_compositor.sv =====
// ascii_text_byte_compositor
// Draws scaled 5x7 text into framebuffer bytes as they stream past.
// Request channel (req_valid / req_stall): req_cmd load places req_char_code
// in slot req_char_slot of the text store; req_cmd composite takes one frame
// byte with its byte column and frame row. Every request word gives exactly
// one response word on rsp_valid / rsp_stall, in request order.
// Setup goes through csr_write_en / csr_index / csr_wdata; the user writes it
// only while no word is in flight, which the block does not enforce. It holds
// frame size, pixel format, origin, scale and text length. One word is taken
// every cycle unless stalled. Words pass the 16-step dot divider that eight
// pixel lanes and the row path each run, then the store read and the merge.
// Reset clears the setup registers (scale 1), the unsupported-character
// flags and all valid bits; store contents stay undefined until loaded.
// A stall on the response side freezes the whole pipeline and raises req_stall
// in the same cycle; the held response does not change.
`default_nettype none
module ascii_text_byte_compositor
   import atbc_pkg::*;
#(
   parameter int MAX_TEXT_CHARS = MAX_TEXT_CHARS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic req_cmd,
   input wire logic [4:0] req_char_slot,
   input wire logic [7:0] req_char_code,
   input wire logic [13:0] req_byte_column,
   input wire logic [15:0] req_pixel_row,
   input wire logic [7:0] req_byte_in,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [7:0] rsp_byte_out,
   output logic [1:0] rsp_status,
   output logic [15:0] rsp_text_width,
   output logic [10:0] rsp_text_height,
   input wire logic csr_write_en,
   input wire logic [2:0] csr_index,
   input wire logic [15:0] csr_wdata
);

   localparam int IW = (MAX_TEXT_CHARS > 1) ? $clog2(MAX_TEXT_CHARS) : 1;

   logic adv;
   logic rsp_valid_ff;

   // setup registers
   logic [15:0] fw_ff, fh_ff, ox_ff, oy_ff;
   logic fmt_ff;
   logic [7:0] scale_ff;
   logic [5:0] len_ff;
   logic [15:0] tw_ff;
   logic [10:0] th_ff;
   logic arg_err_ff, fit_err_ff;
   logic [MAX_TEXT_CHARS-1:0] len_mask_ff;
   logic [8:0] cells_w;
   logic [15:0] tw_in;
   logic [10:0] th_in;
   logic [MAX_TEXT_CHARS-1:0] len_mask_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= '0;
         fh_ff <= '0;
         fmt_ff <= FMT_1BPP;
         ox_ff <= '0;
         oy_ff <= '0;
         scale_ff <= 8'd1;
         len_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_FRAME_WIDTH: fw_ff <= csr_wdata;
            REG_FRAME_HEIGHT: fh_ff <= csr_wdata;
            REG_PIXEL_FORMAT: fmt_ff <= csr_wdata[0];
            REG_ORIGIN_X: ox_ff <= csr_wdata;
            REG_ORIGIN_Y: oy_ff <= csr_wdata;
            REG_GLYPH_SCALE: scale_ff <= csr_wdata[7:0];
            REG_TEXT_LENGTH: len_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   assign cells_w = 9'(9'(len_ff) * 9'd6) - 9'd1;
   assign tw_in = 16'(17'(cells_w) * 17'(scale_ff));
   assign th_in = 11'(11'(scale_ff) * 11'd7);

   always_comb begin
      for (int i = 0; i < MAX_TEXT_CHARS; i++) begin
         len_mask_in[i] = (7'(i) < {1'b0, len_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= '0;
         th_ff <= '0;
         arg_err_ff <= 1'b1;
         fit_err_ff <= 1'b0;
         len_mask_ff <= '0;
      end else begin
         tw_ff <= tw_in;
         th_ff <= th_in;
         len_mask_ff <= len_mask_in;
         arg_err_ff <= (fw_ff == 16'd0) || (fh_ff == 16'd0) || (scale_ff == 8'd0)
            || (len_ff == 6'd0) || (7'(len_ff) > 7'(MAX_TEXT_CHARS));
         fit_err_ff <= (ox_ff >= fw_ff) || (oy_ff >= fh_ff)
            || (tw_ff > 16'(fw_ff - ox_ff)) || ({5'd0, th_ff} > 16'(fh_ff - oy_ff));
      end
   end

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // input stage
   meta_type s0_ff;
   logic [13:0] bcol_ff;
   logic [15:0] row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.vld <= 1'b0;
      end else if (adv) begin
         s0_ff.vld <= req_valid;
         s0_ff.cmd <= req_cmd;
         s0_ff.slot <= req_char_slot;
         s0_ff.code <= req_char_code;
         s0_ff.byte_in <= req_byte_in;
         s0_ff.yin <= 1'b0;
         bcol_ff <= req_byte_column;
         row_ff <= req_pixel_row;
      end
   end

   // row path
   logic [15:0] dy;
   logic yin_in;
   logic [DIV_W-1:0] gy_quo;
   meta_type s0_meta;

   assign dy = row_ff - oy_ff;
   assign yin_in = (row_ff >= oy_ff) && (dy < {5'd0, th_ff});

   always_comb begin
      s0_meta = s0_ff;
      s0_meta.yin = yin_in;
   end

   atbc_div u_row_div (
      .clock(clock),
      .enable(adv),
      .divisor(scale_ff),
      .dividend(dy),
      .quotient(gy_quo)
   );

   // pixel lanes
   logic [LANES-1:0] lane_xin;
   logic [IW-1:0] lane_cell [0:LANES-1];
   logic [2:0] lane_gx [0:LANES-1];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [16:0] px;
      logic en;
      assign px = (fmt_ff == FMT_1BPP) ? {bcol_ff, 3'(k)} : {1'b0, bcol_ff, 2'(k)};
      assign en = (fmt_ff == FMT_1BPP) || (k < LANES / 2);
      atbc_lane #(.MAX_TEXT_CHARS(MAX_TEXT_CHARS)) u_lane (
         .clock(clock),
         .enable(adv),
         .lane_en(en),
         .px(px),
         .origin_x(ox_ff),
         .text_w(tw_ff),
         .scale(scale_ff),
         .xin(lane_xin[k]),
         .char_idx(lane_cell[k]),
         .gx(lane_gx[k])
      );
   end

   meta_type pipe_ff [0:DIV_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < DIV_W; j++) begin
            pipe_ff[j].vld <= 1'b0;
         end
      end else if (adv) begin
         pipe_ff[0] <= s0_meta;
         for (int j = 1; j < DIV_W; j++) begin
            pipe_ff[j] <= pipe_ff[j-1];
         end
      end
   end

   meta_type m1_ff;
   logic [2:0] gy_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_ff.vld <= 1'b0;
      end else if (adv) begin
         m1_ff <= pipe_ff[DIV_W-1];
         gy_m1_ff <= gy_quo[2:0];
      end
   end

   // store access: the cells under one word are base, base+1, base+2
   logic [IW-1:0] cbase;
   logic [IW:0] cnext1, cnext2;
   logic [IW-1:0] addr0, addr1, addr2;
   logic [1:0] offs_in [0:LANES-1];
   logic [IW-1:0] wr_slot;
   logic wr_en;
   logic bad_in;

   always_comb begin
      cbase = lane_cell[LANES-1];
      for (int k = LANES - 1; k >= 0; k--) begin
         if (lane_xin[k]) begin
            cbase = lane_cell[k];
         end
      end
      for (int k = 0; k < LANES; k++) begin
         offs_in[k] = 2'(lane_cell[k] - cbase);
      end
   end

   assign cnext1 = {1'b0, cbase} + (IW+1)'(1);
   assign cnext2 = {1'b0, cbase} + (IW+1)'(2);
   assign addr0 = cbase;
   assign addr1 = (cnext1 < (IW+1)'(MAX_TEXT_CHARS)) ? cnext1[IW-1:0] : '0;
   assign addr2 = (cnext2 < (IW+1)'(MAX_TEXT_CHARS)) ? cnext2[IW-1:0] : '0;

   assign wr_slot = IW'(m1_ff.slot);
   assign wr_en = adv && m1_ff.vld && (m1_ff.cmd == CMD_LOAD)
      && (6'(m1_ff.slot) < 6'(MAX_TEXT_CHARS));

   logic [MAX_TEXT_CHARS-1:0] flags_ff;

   assign bad_in = |(flags_ff & len_mask_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else if (wr_en) begin
         flags_ff[wr_slot] <= !glyph_ok(m1_ff.code);
      end
   end

   logic [7:0] mem_a [0:MAX_TEXT_CHARS-1];
   logic [7:0] mem_b [0:MAX_TEXT_CHARS-1];
   logic [7:0] rd0_ff, rd1_ff, rd2_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_a[wr_slot] <= m1_ff.code;
         mem_b[wr_slot] <= m1_ff.code;
      end
      if (adv) begin
         rd0_ff <= mem_a[addr0];
         rd1_ff <= mem_a[addr1];
         rd2_ff <= mem_b[addr2];
      end
   end

   meta_type m2_ff;
   logic [2:0] gy_m2_ff;
   logic bad_m2_ff;
   logic [LANES-1:0] hit_m2_ff;
   logic [1:0] offs_m2_ff [0:LANES-1];
   logic [2:0] gx_m2_ff [0:LANES-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_ff.vld <= 1'b0;
      end else if (adv) begin
         m2_ff <= m1_ff;
         gy_m2_ff <= gy_m1_ff;
         bad_m2_ff <= bad_in;
         for (int k = 0; k < LANES; k++) begin
            hit_m2_ff[k] <= lane_xin[k] && (lane_gx[k] < 3'd5);
            offs_m2_ff[k] <= offs_in[k];
            gx_m2_ff[k] <= lane_gx[k];
         end
      end
   end

   // merge lanes into the word
   logic [LANES-1:0] ink;
   logic [7:0] byte_ink;
   logic [7:0] out_byte_in;
   logic [1:0] out_status_in;
   logic [15:0] out_tw_in;
   logic [10:0] out_th_in;

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         logic [7:0] ch;
         logic [4:0] rw;
         case (offs_m2_ff[k])
            2'd0: ch = rd0_ff;
            2'd1: ch = rd1_ff;
            default: ch = rd2_ff;
         endcase
         rw = glyph_row(ch, gy_m2_ff);
         ink[k] = hit_m2_ff[k] && m2_ff.yin && rw[3'd4 - gx_m2_ff[k]];
      end
      byte_ink = m2_ff.byte_in;
      if (fmt_ff == FMT_1BPP) begin
         for (int k = 0; k < LANES; k++) begin
            if (ink[k]) begin
               byte_ink[7-k] = 1'b1;
            end
         end
      end else begin
         for (int k = 0; k < LANES / 2; k++) begin
            if (ink[k]) begin
               byte_ink[(3-k)*2 +: 2] = 2'b00;
            end
         end
      end
   end

   always_comb begin
      out_byte_in = m2_ff.byte_in;
      out_status_in = ST_OK;
      out_tw_in = tw_ff;
      out_th_in = th_ff;
      if (m2_ff.cmd == CMD_LOAD) begin
         out_byte_in = '0;
         out_tw_in = '0;
         out_th_in = '0;
      end else if (arg_err_ff || bad_m2_ff) begin
         out_status_in = ST_ARG;
         out_tw_in = '0;
         out_th_in = '0;
      end else if (fit_err_ff) begin
         out_status_in = ST_FIT;
      end else begin
         out_byte_in = byte_ink;
      end
   end

   logic [7:0] rsp_byte_ff;
   logic [1:0] rsp_status_ff;
   logic [15:0] rsp_tw_ff;
   logic [10:0] rsp_th_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m2_ff.vld;
         rsp_byte_ff <= out_byte_in;
         rsp_status_ff <= out_status_in;
         rsp_tw_ff <= out_tw_in;
         rsp_th_ff <= out_th_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte_out = rsp_byte_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_text_width = rsp_tw_ff;
   assign rsp_text_height = rsp_th_ff;

   a_arg_no_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_ARG) |-> (rsp_text_width == 16'd0
         && rsp_text_height == 11'd0))
      else $error("invalid argument word carries a text size");

   a_ok_has_height: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_OK && m2_ff.vld) |-> (arg_err_ff == 1'b0
         || m2_ff.cmd == CMD_LOAD || rsp_text_height != 11'd0 || rsp_byte_out == 8'd0))
      else $error("ok word with zero height");

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule
`default_nettype wire

// ===== sim/tb_ascii_text_byte_compositor.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_ascii_text_byte_compositor;
   import atbc_pkg::*;

   localparam int SETTLE = 30;
   localparam int LIMIT = 400000;

   typedef struct {
      logic cmd;
      logic [4:0] slot;
      logic [7:0] code;
      logic [13:0] bcol;
      logic [15:0] row;
      logic [7:0] bin;
   } word_type;

   typedef struct {
      logic [7:0] pix;
      logic [1:0] status;
      logic [15:0] tw;
      logic [10:0] th;
   } overlay_type;

   logic clock, reset;
   logic req_valid, req_stall, req_cmd;
   logic [4:0] req_char_slot;
   logic [7:0] req_char_code;
   logic [13:0] req_byte_column;
   logic [15:0] req_pixel_row;
   logic [7:0] req_byte_in;
   logic rsp_valid, rsp_stall;
   logic [7:0] rsp_byte_out;
   logic [1:0] rsp_status;
   logic [15:0] rsp_text_width;
   logic [10:0] rsp_text_height;
   logic csr_write_en;
   logic [2:0] csr_index;
   logic [15:0] csr_wdata;

   word_type word_q[$];
   word_type nxt;
   overlay_type overlay_q[$];
   logic req_taken;
   logic calm;
   int unsigned cycles, errors, queued_n, taken_n, checked_n, phase_n;

   // model copy of the setup and the text store
   logic [15:0] m_fw, m_fh, m_ox, m_oy;
   logic m_fmt;
   logic [7:0] m_scale;
   logic [5:0] m_len;
   logic [7:0] m_text[32];
   logic m_bad[32];

   ascii_text_byte_compositor dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [55:0] font_of(input logic [7:0] c);
      case (c)
         8'h41: return 56'h0E11111F111111; 8'h42: return 56'h1E11111E11111E;
         8'h43: return 56'h0E11101010110E; 8'h44: return 56'h1E11111111111E;
         8'h45: return 56'h1F10101E10101F; 8'h46: return 56'h1F10101E101010;
         8'h47: return 56'h0E11101711110F; 8'h48: return 56'h1111111F111111;
         8'h49: return 56'h0E04040404040E; 8'h4A: return 56'h0702020212120C;
         8'h4B: return 56'h11121418141211; 8'h4C: return 56'h1010101010101F;
         8'h4D: return 56'h111B1515111111; 8'h4E: return 56'h11191513111111;
         8'h4F: return 56'h0E11111111110E; 8'h50: return 56'h1E11111E101010;
         8'h51: return 56'h0E11111115120D; 8'h52: return 56'h1E11111E141211;
         8'h53: return 56'h0F10100E01011E; 8'h54: return 56'h1F040404040404;
         8'h55: return 56'h1111111111110E; 8'h56: return 56'h1111111111 << 16 | 56'h0A04;
         8'h57: return 56'h1111111515150A; 8'h58: return 56'h11110A040A1111;
         8'h59: return 56'h11110A04040404; 8'h5A: return 56'h1F01020408101F;
         8'h61: return 56'h00000E010F110F; 8'h62: return 56'h10101E1111111E;
         8'h63: return 56'h00000F1010100F; 8'h64: return 56'h01010F1111110F;
         8'h65: return 56'h00000E111F100E; 8'h66: return 56'h0609081C080808;
         8'h67: return 56'h00000F110F010E; 8'h68: return 56'h10101E11111111;
         8'h69: return 56'h04000C0404040E; 8'h6A: return 56'h0200060202120C;
         8'h6B: return 56'h10101214181412; 8'h6C: return 56'h0C04040404040E;
         8'h6D: return 56'h00001A15151515; 8'h6E: return 56'h00001E11111111;
         8'h6F: return 56'h00000E1111110E; 8'h70: return 56'h00001E111E1010;
         8'h71: return 56'h00000F110F0101; 8'h72: return 56'h00001619101010;
         8'h73: return 56'h00000F100E011E; 8'h74: return 56'h08081C08080906;
         8'h75: return 56'h0000111111130D; 8'h76: return 56'h0000111111 << 16 | 56'h0A04;
         8'h77: return 56'h0000111115150A; 8'h78: return 56'h0000110A040A11;
         8'h79: return 56'h00001111 << 24 | 56'h0F010E; 8'h7A: return 56'h00001F0204081F;
         8'h30: return 56'h0E11131519110E; 8'h31: return 56'h040C040404040E;
         8'h32: return 56'h0E11010204081F; 8'h33: return 56'h1E01010E01011E;
         8'h34: return 56'h02060A121F0202; 8'h35: return 56'h1F10101E01011E;
         8'h36: return 56'h0E10101E11110E; 8'h37: return 56'h1F010204080808;
         8'h38: return 56'h0E11110E11110E; 8'h39: return 56'h0E11110F01010E;
         8'h21: return 56'h04040404040004; 8'h2D: return 56'h0000001F000000;
         8'h2E: return 56'h00000000000004; 8'h3A: return 56'h00040000040000;
         8'h3F: return 56'h0E110102040004; 8'h5F: return 56'h0000000000001F;
         default: return 56'h0;
      endcase
   endfunction

   function automatic logic has_glyph(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)
         || (c >= 8'h30 && c <= 8'h39) || c == 8'h20 || c == 8'h21 || c == 8'h2D
         || c == 8'h2E || c == 8'h3A || c == 8'h3F || c == 8'h5F;
   endfunction

   function automatic logic inked(input int unsigned px, input int unsigned py);
      int unsigned tw, th, col, cidx, gx, gy;
      logic [55:0] f;
      tw = (6 * m_len - 1) * m_scale;
      th = 7 * m_scale;
      if (px < m_ox || px - m_ox >= tw || py < m_oy || py - m_oy >= th) return 1'b0;
      col = (px - m_ox) / m_scale;
      cidx = col / 6;
      gx = col % 6;
      gy = (py - m_oy) / m_scale;
      if (gx >= 5 || gy >= 7 || cidx >= 32) return 1'b0;
      f = font_of(m_text[cidx]);
      return f[(6 - gy) * 8 + 4 - gx];
   endfunction

   function automatic overlay_type overlay_of(input word_type w);
      overlay_type o;
      int unsigned tw, th;
      o = '{8'd0, ST_OK, 16'd0, 11'd0};
      if (w.cmd == CMD_LOAD) begin
         m_text[w.slot] = w.code;
         m_bad[w.slot] = !has_glyph(w.code);
         return o;
      end
      o.pix = w.bin;
      if (m_fw == 0 || m_fh == 0 || m_scale == 0 || m_len == 0 || m_len > 32) begin
         o.status = ST_ARG;
         return o;
      end
      for (int i = 0; i < m_len; i++)
         if (m_bad[i]) begin
            o.status = ST_ARG;
            return o;
         end
      tw = ((6 * m_len - 1) * m_scale) & 16'hFFFF;
      th = (7 * m_scale) & 11'h7FF;
      o.tw = 16'(tw);
      o.th = 11'(th);
      if (m_ox >= m_fw || m_oy >= m_fh || tw > m_fw - m_ox || th > m_fh - m_oy) begin
         o.status = ST_FIT;
         return o;
      end
      if (m_fmt == FMT_1BPP) begin
         for (int k = 0; k < 8; k++)
            if (inked(w.bcol * 8 + k, w.row)) o.pix[7 - k] = 1'b1;
      end else begin
         for (int k = 0; k < 4; k++)
            if (inked(w.bcol * 4 + k, w.row)) o.pix[(3 - k) * 2 +: 2] = 2'b00;
      end
      return o;
   endfunction

   // request side
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (word_q.size() > 0 && (calm || $urandom_range(99) >= 9)) begin
               nxt = word_q.pop_front();
               req_valid <= 1'b1;
               req_cmd <= nxt.cmd;
               req_char_slot <= nxt.slot;
               req_char_code <= nxt.code;
               req_byte_column <= nxt.bcol;
               req_pixel_row <= nxt.row;
               req_byte_in <= nxt.bin;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= !calm && $urandom_range(99) < 9;
      end
   end

   // acceptance, prediction and response check
   always @(posedge clock) begin
      overlay_type e;
      cycles++;
      if (cycles > LIMIT) begin
         $display("%0t timeout", $time);
         $display("simulation failed");
         $finish;
      end
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         overlay_q.push_back(overlay_of('{req_cmd, req_char_slot, req_char_code,
            req_byte_column, req_pixel_row, req_byte_in}));
         taken_n++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (overlay_q.size() == 0) begin
            errors++;
            $display("%0t unexpected word: byte %h status %0d", $time, rsp_byte_out,
               rsp_status);
         end else begin
            e = overlay_q.pop_front();
            checked_n++;
            if (rsp_byte_out !== e.pix || rsp_status !== e.status
                  || rsp_text_width !== e.tw || rsp_text_height !== e.th) begin
               errors++;
               $display("%0t mismatch: expected %h/%0d/%0d/%0d actual %h/%0d/%0d/%0d",
                  $time, e.pix, e.status, e.tw, e.th, rsp_byte_out, rsp_status,
                  rsp_text_width, rsp_text_height);
            end
         end
      end
   end

   task automatic put(input word_type w);
      word_q.push_back(w);
      queued_n++;
   endtask

   task automatic load(input int s, input logic [7:0] c);
      put('{CMD_LOAD, s[4:0], c, 14'($urandom), 16'($urandom), 8'($urandom)});
   endtask

   task automatic blend(input int bc, input int r, input logic [7:0] b);
      put('{CMD_COMPOSITE, 5'($urandom), 8'($urandom), bc[13:0], r[15:0], b});
   endtask

   task automatic drain();
      while (taken_n != queued_n || overlay_q.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_reg(input logic [2:0] idx, input logic [15:0] v);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         REG_FRAME_WIDTH: m_fw = v;
         REG_FRAME_HEIGHT: m_fh = v;
         REG_PIXEL_FORMAT: m_fmt = v[0];
         REG_ORIGIN_X: m_ox = v;
         REG_ORIGIN_Y: m_oy = v;
         REG_GLYPH_SCALE: m_scale = v[7:0];
         REG_TEXT_LENGTH: m_len = v[5:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic setup(input int fw, input int fh, input int fmt, input int ox,
                        input int oy, input int sc, input int len);
      set_reg(REG_FRAME_WIDTH, fw[15:0]);
      set_reg(REG_FRAME_HEIGHT, fh[15:0]);
      set_reg(REG_PIXEL_FORMAT, fmt[15:0]);
      set_reg(REG_ORIGIN_X, ox[15:0]);
      set_reg(REG_ORIGIN_Y, oy[15:0]);
      set_reg(REG_GLYPH_SCALE, sc[15:0]);
      set_reg(REG_TEXT_LENGTH, len[15:0]);
   endtask

   function automatic logic [7:0] good_code();
      logic [7:0] punct[7] = '{8'h20, 8'h21, 8'h2D, 8'h2E, 8'h3A, 8'h3F, 8'h5F};
      case ($urandom_range(3))
         0: return 8'($urandom_range(8'h5A, 8'h41));
         1: return 8'($urandom_range(8'h7A, 8'h61));
         2: return 8'($urandom_range(8'h39, 8'h30));
         default: return punct[$urandom_range(6)];
      endcase
   endfunction

   function automatic logic [7:0] any_code();
      return ($urandom_range(99) < 80) ? good_code() : 8'($urandom);
   endfunction

   initial begin
      int fw, fh, fmt, ox, oy, sc, len, tw, th, ppb, x, y, pick;
      logic [7:0] hello[12];
      hello = '{8'h41, 8'h7A, 8'h39, 8'h21, 8'h2D, 8'h2E, 8'h3A,
                8'h3F, 8'h5F, 8'h20, 8'hFF, 8'h00};
      cycles = 0; errors = 0; queued_n = 0; taken_n = 0; checked_n = 0; phase_n = 0;
      calm = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0; req_taken = 1'b0; req_cmd = CMD_LOAD;
      req_char_slot = '0; req_char_code = '0; req_byte_column = '0;
      req_pixel_row = '0; req_byte_in = '0;
      rsp_stall = 1'b0;
      csr_write_en = 1'b0; csr_index = REG_FRAME_WIDTH; csr_wdata = '0;
      m_fw = 0; m_fh = 0; m_fmt = FMT_1BPP; m_ox = 0; m_oy = 0; m_scale = 1; m_len = 0;
      foreach (m_bad[i]) begin
         m_bad[i] = 1'b0;
         m_text[i] = 8'h00;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset setup is invalid, then a glyph tour with edge bytes
      blend(0, 0, 8'hA5);
      for (int i = 0; i < 12; i++) load(i, hello[i]);
      drain();
      setup(64, 16, FMT_1BPP, 0, 0, 1, 10);
      for (int r = 0; r < 7; r++) blend(r, r, (r % 2) ? 8'hFF : 8'h00);
      blend(16383, 65535, 8'hFF);
      drain();
      setup(65535, 65535, FMT_2BPP, 1, 2, 1, 12);
      blend(0, 2, 8'hFF);
      drain();
      setup(65535, 65535, FMT_2BPP, 65535, 65535, 255, 10);
      blend(0, 0, 8'h3C);
      drain();

      // fill the whole store before any random text is rendered
      for (int i = 0; i < 32; i++) load(i, good_code());
      drain();

      for (int p = 0; p < 24; p++) begin
         phase_n++;
         calm = (p >= 8 && p < 11);
         pick = $urandom_range(99);
         fmt = $urandom_range(1);
         sc = (pick < 70) ? $urandom_range(3, 1) : (pick < 85) ? $urandom_range(12, 4)
            : (pick < 93) ? 255 : 0;
         len = (pick % 10 < 7) ? $urandom_range(6, 1) : (pick % 10 < 8) ? 32
            : (pick % 10 < 9) ? 0 : $urandom_range(63, 33);
         if (p == 5) begin
            sc = 255;
            len = 1;
         end
         tw = (6 * len - 1) * sc;
         th = 7 * sc;
         ox = $urandom_range(40);
         oy = $urandom_range(20);
         fw = ox + tw + $urandom_range(30);
         fh = oy + th + $urandom_range(10);
         if (pick % 7 == 0) fw = $urandom_range(1, 60);
         if (pick % 11 == 0) fh = 0;
         if (pick % 13 == 0) fw = 0;
         if (p == 7) begin
            fw = 65535;
            fh = 65535;
            ox = 65535;
            oy = 0;
         end
         if (fw > 65535) fw = 65535;
         if (fh > 65535) fh = 65535;
         setup(fw, fh, fmt, ox, oy, sc, len);
         if ($urandom_range(99) < 60)
            for (int i = 0; i < len && i < 32; i++) load(i, good_code());
         ppb = fmt ? 4 : 8;
         for (int n = 0; n < 43; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
               load($urandom_range(31), any_code());
            end else if (pick < 16) begin
               put('{1'($urandom), 5'($urandom), 8'($urandom), 14'($urandom),
                  16'($urandom), 8'($urandom)});
            end else begin
               x = ox - 8 + $urandom_range(tw + 16);
               y = oy - 2 + $urandom_range(th + 4);
               if (x < 0) x = 0;
               if (y < 0) y = 0;
               blend(x / ppb, y, ($urandom_range(3) == 0) ? 8'($urandom)
                  : ($urandom_range(1) ? 8'hFF : 8'h00));
            end
         end
         drain();
      end

      $display("%0d words checked over %0d random setups, both pixel formats,",
         checked_n, phase_n);
      $display("scales 0 to 255, lengths 0 to 63, fit and invalid cases");
      if (errors == 0 && overlay_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ===== filelist.f =====
src/atbc_pkg.sv
src/atbc_div.sv
src/atbc_lane.sv
src/ascii_text_byte_compositor.sv
sim/tb_ascii_text_byte_compositor.sv
